FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files of the recognizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/dsr_pkg.sv
// Package with the types and constants of the recognizer.
`default_nettype none

package dsr_pkg;

  localparam int unsigned STATE_W = 4;
  localparam int unsigned SYM_W   = 4;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned ALPHA_W = 10;
  localparam int unsigned FINAL_W = 16;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  // Character code of the digit zero.
  localparam logic [CODE_W-1:0] DIGIT_ZERO = 8'd48;

  // Input operation codes.
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_CHAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_EMPTY = 2'd2;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_ALPHA  = 2'd1;
  localparam logic [1:0] REG_FINAL  = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_CHAR,
    CMD_EMPTY
  } cmd_kind_e;

  // Classified item handed from the front to the back.
  typedef struct packed {
    cmd_kind_e          kind;
    logic               last;
    logic               sym_ok;
    logic [SYM_W-1:0]   sym;
    logic [STATE_W-1:0] from;
    logic [STATE_W-1:0] dest;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic               accepted;
    logic [STATE_W-1:0] end_state;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dsr_fifo.sv
// Small register queue used between the front, the back and the result port.
`default_nettype none

module dsr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             valid_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dsr_front.sv
// Front end: accepts input items and classifies them into commands.
`default_nettype none

module dsr_front import dsr_pkg::*; #(
  parameter int unsigned NUM_SYMBOLS = 10
) (
  input  logic               accept_i,
  input  logic [OP_W-1:0]    op_i,
  input  logic [STATE_W-1:0] from_state_i,
  input  logic [SYM_W-1:0]   symbol_in_i,
  input  logic [STATE_W-1:0] dest_state_i,
  input  logic [CODE_W-1:0]  char_code_i,
  input  logic               last_char_i,
  input  logic [ALPHA_W-1:0] alphabet_mask_i,
  output logic               cmd_push_o,
  output cmd_t               cmd_o
);

  // Only the symbols that the alphabet mask covers can ever be valid.
  localparam int unsigned COLS = (NUM_SYMBOLS < ALPHA_W) ? NUM_SYMBOLS : ALPHA_W;

  logic [CODE_W-1:0] diff;
  logic              sym_ok;

  // A character is a valid symbol when it is a digit inside the alphabet.
  assign diff   = char_code_i - DIGIT_ZERO;
  assign sym_ok = (char_code_i >= DIGIT_ZERO) && (diff < CODE_W'(COLS)) &&
                  alphabet_mask_i[diff[SYM_W-1:0]];

  // Map the operation code; the unused code is dropped here.
  always_comb begin
    cmd_o.last   = last_char_i;
    cmd_o.sym_ok = sym_ok;
    cmd_o.from   = from_state_i;
    cmd_o.dest   = dest_state_i;
    cmd_o.sym    = diff[SYM_W-1:0];
    cmd_o.kind   = CMD_CHAR;
    cmd_push_o   = 1'b0;
    case (op_i)
      OP_WRITE: begin
        cmd_o.kind = CMD_WRITE;
        cmd_o.sym  = symbol_in_i;
        cmd_push_o = accept_i;
      end
      OP_CHAR: begin
        cmd_o.kind = CMD_CHAR;
        cmd_push_o = accept_i;
      end
      OP_EMPTY: begin
        cmd_o.kind = CMD_EMPTY;
        cmd_push_o = accept_i;
      end
      default: begin
        cmd_push_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dsr_back.sv
// Back end: holds the transition table and steps the automaton.
`default_nettype none

module dsr_back import dsr_pkg::*; #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned NUM_SYMBOLS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output res_t               res_o,
  input  logic [STATE_W-1:0] start_state_i,
  input  logic [FINAL_W-1:0] final_mask_i
);

  // States and symbols beyond these bounds can never be reached or read.
  localparam int unsigned ROWS      = (NUM_STATES < (1 << STATE_W)) ? NUM_STATES
                                                                    : (1 << STATE_W);
  localparam int unsigned COLS      = (NUM_SYMBOLS < ALPHA_W) ? NUM_SYMBOLS : ALPHA_W;
  localparam int unsigned TBL_DEPTH = ROWS * COLS;
  localparam int unsigned TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  // Table storage, its written marks and the registered read port.
  logic [STATE_W-1:0]   tbl_mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] tbl_vld_q;
  logic [STATE_W-1:0]   rd_data_q;
  logic                 rd_vld_q;

  // Automaton state after the last completed command.
  logic [STATE_W-1:0] cur_q, cur_d;
  logic               rej_q, rej_d;
  logic               in_str_q, in_str_d;

  // Execute stage: a character or empty item, with its table read if it made one.
  logic               ex_vld_q, ex_vld_d;
  logic               ex_look_q, ex_look_d;
  logic               ex_fin_q, ex_fin_d;
  logic [STATE_W-1:0] ex_cur_q, ex_cur_d;
  logic               ex_rej_q, ex_rej_d;

  logic               ex_fire;
  logic               issue;
  logic               tbl_we;
  logic               rd_en;
  logic [TBL_AW-1:0]  wr_addr;
  logic [TBL_AW-1:0]  rd_addr;
  logic [STATE_W-1:0] nxt;
  logic [STATE_W-1:0] res_cur;
  logic               res_rej;
  logic               prev_in;
  logic [STATE_W-1:0] prev_cur;
  logic               prev_rej;
  logic [STATE_W-1:0] base_cur;
  logic               base_rej;
  logic               state_ok;

  // The looked-up destination; an entry never written reads as missing.
  assign nxt = rd_vld_q ? rd_data_q : '0;

  // Resolve the command held in the execute stage.
  always_comb begin
    res_cur = ex_cur_q;
    res_rej = ex_rej_q;
    if (ex_look_q) begin
      if (nxt == '0) begin
        res_rej = 1'b1;
      end else begin
        res_cur = nxt;
      end
    end
  end

  // A finishing command moves on only when the result queue has room.
  assign ex_fire    = ex_vld_q && (!ex_fin_q || !res_full_i);
  assign res_push_o = ex_vld_q && ex_fin_q && !res_full_i;

  always_comb begin
    res_o.accepted  = !res_rej && final_mask_i[res_cur];
    res_o.end_state = res_rej ? '0 : res_cur;
  end

  // State seen by the command at the head of the queue; a new string starts
  // from the start state.
  assign prev_in  = ex_vld_q ? !ex_fin_q : in_str_q;
  assign prev_cur = ex_vld_q ? res_cur : cur_q;
  assign prev_rej = ex_vld_q ? res_rej : rej_q;
  assign base_cur = prev_in ? prev_cur : start_state_i;
  assign base_rej = prev_in ? prev_rej : 1'b0;
  assign state_ok = ({1'b0, base_cur} < (STATE_W + 1)'(ROWS));

  // The head command issues when the execute stage is free or moving on.
  assign issue     = cmd_valid_i && (!ex_vld_q || ex_fire);
  assign cmd_pop_o = issue;

  // Table write is kept only inside the readable range.
  assign tbl_we  = issue && (cmd_i.kind == CMD_WRITE) &&
                   ({1'b0, cmd_i.from} < (STATE_W + 1)'(ROWS)) &&
                   ({1'b0, cmd_i.sym} < (SYM_W + 1)'(COLS));
  assign rd_en   = issue && (cmd_i.kind == CMD_CHAR) && !base_rej &&
                   cmd_i.sym_ok && state_ok;
  assign wr_addr = TBL_AW'(cmd_i.from) * TBL_AW'(COLS) + TBL_AW'(cmd_i.sym);
  assign rd_addr = TBL_AW'(base_cur) * TBL_AW'(COLS) + TBL_AW'(cmd_i.sym);

  // Load the execute stage with characters and empty items.
  always_comb begin
    ex_vld_d  = ex_vld_q;
    ex_look_d = ex_look_q;
    ex_fin_d  = ex_fin_q;
    ex_cur_d  = ex_cur_q;
    ex_rej_d  = ex_rej_q;
    if (ex_fire) begin
      ex_vld_d = 1'b0;
    end
    if (issue && cmd_i.kind != CMD_WRITE) begin
      ex_vld_d  = 1'b1;
      ex_look_d = rd_en;
      ex_fin_d  = (cmd_i.kind == CMD_EMPTY) || cmd_i.last;
      ex_cur_d  = base_cur;
      ex_rej_d  = base_rej;
      if (cmd_i.kind == CMD_CHAR && !base_rej && !rd_en) begin
        ex_rej_d = 1'b1;
      end
    end
  end

  // State update when the execute stage completes; a string end returns to start.
  always_comb begin
    cur_d    = cur_q;
    rej_d    = rej_q;
    in_str_d = in_str_q;
    if (ex_fire) begin
      if (ex_fin_q) begin
        cur_d    = start_state_i;
        rej_d    = 1'b0;
        in_str_d = 1'b0;
      end else begin
        cur_d    = res_cur;
        rej_d    = res_rej;
        in_str_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      rej_q     <= 1'b0;
      in_str_q  <= 1'b0;
      ex_vld_q  <= 1'b0;
      ex_look_q <= 1'b0;
      ex_fin_q  <= 1'b0;
      ex_cur_q  <= '0;
      ex_rej_q  <= 1'b0;
    end else begin
      cur_q     <= cur_d;
      rej_q     <= rej_d;
      in_str_q  <= in_str_d;
      ex_vld_q  <= ex_vld_d;
      ex_look_q <= ex_look_d;
      ex_fin_q  <= ex_fin_d;
      ex_cur_q  <= ex_cur_d;
      ex_rej_q  <= ex_rej_d;
    end
  end

  // Written marks; reset leaves every transition missing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= tbl_vld_q[rd_addr];
      end
    end
  end

  // Table storage; at most one command issues per cycle, so a write and a read never meet.
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[wr_addr] <= cmd_i.dest;
    end
    if (rd_en) begin
      rd_data_q <= tbl_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dfa_string_recognizer_top.sv
// Top level of the table driven automaton string recognizer.
//
//   channel   handshake              payload
//   input     push / full            op_i from_state_i symbol_in_i dest_state_i
//                                    char_code_i last_char_i
//   result    empty / pop            accepted_o end_state_o
//   config    psel penable pwrite    paddr pwdata prdata, pready tied high
//
// One item is taken every cycle while full is low; the back end issues one table read
// per cycle while the execute stage can move on and resolves it in the next, the read
// data feeding the address of the following character. A result passes from the
// command queue through the execute stage into the result queue before it shows on
// the result ports. Reset is asynchronous and clears the written marks of the table,
// the registers and both queues at once. A stalled result side fills the result
// queue, the execute stage and then the command queue, after which full stays high.
`default_nettype none

`include "assert_macros.svh"

module dfa_string_recognizer_top import dsr_pkg::*; #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned NUM_SYMBOLS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input queue side.
  input  logic               push,
  output logic               full,
  input  logic [OP_W-1:0]    op_i,
  input  logic [STATE_W-1:0] from_state_i,
  input  logic [SYM_W-1:0]   symbol_in_i,
  input  logic [STATE_W-1:0] dest_state_i,
  input  logic [CODE_W-1:0]  char_code_i,
  input  logic               last_char_i,
  // Result queue side.
  output logic               empty,
  input  logic               pop,
  output logic               accepted_o,
  output logic [STATE_W-1:0] end_state_o,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int unsigned CMD_W = $bits(cmd_t);
  localparam int unsigned RES_W = $bits(res_t);

  logic [STATE_W-1:0] start_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [FINAL_W-1:0] final_q;
  logic               cfg_we;

  logic               cmd_push, cmd_full, cmd_valid, cmd_pop;
  cmd_t               cmd_in, cmd_head;
  logic               res_push, res_full, res_valid;
  res_t               res_in, res_head;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      alpha_q <= '0;
      final_q <= '0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_START: start_q <= pwdata[STATE_W-1:0];
        REG_ALPHA: alpha_q <= pwdata[ALPHA_W-1:0];
        REG_FINAL: final_q <= pwdata[FINAL_W-1:0];
        default:   ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[3:2])
      REG_START: prdata = DATA_W'(start_q);
      REG_ALPHA: prdata = DATA_W'(alpha_q);
      REG_FINAL: prdata = DATA_W'(final_q);
      default:   prdata = '0;
    endcase
  end

  // Front end: classification of accepted items.
  assign full = cmd_full;

  dsr_front #(
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_front (
    .accept_i        (push && !cmd_full),
    .op_i            (op_i),
    .from_state_i    (from_state_i),
    .symbol_in_i     (symbol_in_i),
    .dest_state_i    (dest_state_i),
    .char_code_i     (char_code_i),
    .last_char_i     (last_char_i),
    .alphabet_mask_i (alpha_q),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in)
  );

  // Command queue between front and back.
  dsr_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .valid_o (cmd_valid)
  );

  // Back end: table and automaton state.
  dsr_back #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd_head),
    .cmd_pop_o     (cmd_pop),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_o         (res_in),
    .start_state_i (start_q),
    .final_mask_i  (final_q)
  );

  // Result queue toward the consumer.
  dsr_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .valid_o (res_valid)
  );

  assign empty       = !res_valid;
  assign accepted_o  = res_head.accepted;
  assign end_state_o = res_head.end_state;

  // The back end never pushes a result into a full result queue.
  `ASSERT_IMPL(a_res_no_overflow, res_push, !res_full)
  // A pushed result is waiting on the result ports in the cycle after.
  `ASSERT_NEXT(a_res_visible, res_push, !empty)
  // A character transfer is waiting in the command queue in the cycle after.
  `ASSERT_NEXT(a_char_queued, push && !full && op_i == OP_CHAR, cmd_valid)

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the table driven automaton string recognizer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dsr_pkg::*;

  localparam int unsigned N_STATES     = 16;
  localparam int unsigned N_SYMBOLS    = 10;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_GAP      = 12;
  localparam int unsigned MAX_BURST    = 40;

  // Receiver stall behaviors.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  // One input item as it is presented on the input ports.
  typedef struct {
    logic [OP_W-1:0]    op;
    logic [STATE_W-1:0] from_state;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] dest;
    logic [CODE_W-1:0]  code;
    logic               last;
  } dfa_item_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [OP_W-1:0]    op_i;
  logic [STATE_W-1:0] from_state_i;
  logic [SYM_W-1:0]   symbol_in_i;
  logic [STATE_W-1:0] dest_state_i;
  logic [CODE_W-1:0]  char_code_i;
  logic               last_char_i;
  logic               empty;
  logic               pop = 1'b0;
  logic               accepted_o;
  logic [STATE_W-1:0] end_state_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // Predicted automaton state and configuration.
  logic [STATE_W-1:0] trans_tbl [N_STATES][N_SYMBOLS];
  logic [STATE_W-1:0] dfa_state;
  logic               dfa_rejected;
  logic               dfa_in_string;
  logic [STATE_W-1:0] cfg_start;
  logic [ALPHA_W-1:0] cfg_alpha;
  logic [FINAL_W-1:0] cfg_final;

  // Verdicts predicted but not yet seen on the result ports.
  res_t verdict_q [$];

  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left;
  bit          gaps_on;
  logic        hold_req;
  logic        tail_mode;

  always #1 clk_i = ~clk_i;

  dfa_string_recognizer_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .from_state_i (from_state_i),
    .symbol_in_i  (symbol_in_i),
    .dest_state_i (dest_state_i),
    .char_code_i  (char_code_i),
    .last_char_i  (last_char_i),
    .empty        (empty),
    .pop          (pop),
    .accepted_o   (accepted_o),
    .end_state_o  (end_state_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Reports the string in progress and returns to the start state.
  function automatic void close_string();
    res_t verdict;
    verdict.accepted  = 1'b0;
    verdict.end_state = '0;
    if (!dfa_rejected) begin
      verdict.end_state = dfa_state;
      verdict.accepted  = cfg_final[dfa_state];
    end
    verdict_q     = {verdict_q, verdict};
    dfa_state     = cfg_start;
    dfa_rejected  = 1'b0;
    dfa_in_string = 1'b0;
  endfunction

  // Applies one accepted input item to the predicted automaton.
  function automatic void advance_automaton(dfa_item_t it);
    logic [CODE_W-1:0] sym;
    logic [STATE_W-1:0] nxt;
    sym = it.code - DIGIT_ZERO;
    case (it.op)
      OP_WRITE: begin
        if (it.symbol < N_SYMBOLS) trans_tbl[it.from_state][it.symbol] = it.dest;
      end
      OP_EMPTY: begin
        if (!dfa_in_string) begin
          dfa_state    = cfg_start;
          dfa_rejected = 1'b0;
        end
        close_string();
      end
      OP_CHAR: begin
        if (!dfa_in_string) begin
          dfa_state     = cfg_start;
          dfa_rejected  = 1'b0;
          dfa_in_string = 1'b1;
        end
        if (!dfa_rejected) begin
          if (it.code < DIGIT_ZERO || sym >= N_SYMBOLS) begin
            dfa_rejected = 1'b1;
          end else if (!cfg_alpha[sym[SYM_W-1:0]]) begin
            dfa_rejected = 1'b1;
          end else begin
            nxt = trans_tbl[dfa_state][sym[SYM_W-1:0]];
            if (nxt == '0) dfa_rejected = 1'b1;
            else dfa_state = nxt;
          end
        end
        if (it.last) close_string();
      end
      default: ;
    endcase
  endfunction

  // Fills the fields with random content and the operation with the unused code; callers override what matters.
  function automatic dfa_item_t random_fields();
    dfa_item_t it;
    it.op         = OP_UNUSED;
    it.from_state = STATE_W'($urandom_range(0, 15));
    it.symbol     = SYM_W'($urandom_range(0, 15));
    it.dest       = STATE_W'($urandom_range(0, 15));
    it.code       = CODE_W'($urandom_range(0, 255));
    it.last       = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Picks a digit that most likely follows a live transition.
  function automatic logic [CODE_W-1:0] pick_digit();
    logic [STATE_W-1:0] q;
    int unsigned s;
    q = dfa_in_string ? dfa_state : cfg_start;
    for (int tries = 0; tries < 4; tries++) begin
      s = $urandom_range(0, N_SYMBOLS - 1);
      if (cfg_alpha[s] && trans_tbl[q][s] != '0) return DIGIT_ZERO + CODE_W'(s);
    end
    return DIGIT_ZERO + CODE_W'($urandom_range(0, N_SYMBOLS - 1));
  endfunction

  // Offers one item, with burst gaps, and waits for its transfer.
  task automatic send_item(input dfa_item_t it);
    if (gaps_on && burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk_i);
      burst_left = $urandom_range(1, MAX_BURST);
    end
    if (burst_left > 0) burst_left--;
    push         <= 1'b1;
    op_i         <= it.op;
    from_state_i <= it.from_state;
    symbol_in_i  <= it.symbol;
    dest_state_i <= it.dest;
    char_code_i  <= it.code;
    last_char_i  <= it.last;
    do @(posedge clk_i); while (full);
    advance_automaton(it);
    items_sent++;
  endtask

  task automatic send_write(input logic [STATE_W-1:0] from_q, input logic [SYM_W-1:0] sym,
                            input logic [STATE_W-1:0] dest_q);
    dfa_item_t it;
    it            = random_fields();
    it.op         = OP_WRITE;
    it.from_state = from_q;
    it.symbol     = sym;
    it.dest       = dest_q;
    send_item(it);
  endtask

  task automatic send_char(input logic [CODE_W-1:0] code, input logic last);
    dfa_item_t it;
    it      = random_fields();
    it.op   = OP_CHAR;
    it.code = code;
    it.last = last;
    send_item(it);
  endtask

  task automatic send_empty();
    dfa_item_t it;
    it    = random_fields();
    it.op = OP_EMPTY;
    send_item(it);
  endtask

  task automatic send_noop();
    send_item(random_fields());
  endtask

  // Stops offering and waits until every verdict has arrived and the pipe is quiet.
  task automatic wait_idle();
    push <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One configuration transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_register(input logic [1:0] idx, input string name,
                               input logic [DATA_W-1:0] want);
    logic [DATA_W-1:0] data;
    apb_access(1'b0, {idx, 2'b00}, '0, data);
    if (data !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, data);
      fail_count++;
    end
  endtask

  // Writes a register, mirrors it in the predictor and reads it back.
  task automatic set_register(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] unused;
    logic [DATA_W-1:0] masked;
    string name;
    apb_access(1'b1, {idx, 2'b00}, value, unused);
    case (idx)
      REG_START: begin
        cfg_start = value[STATE_W-1:0];
        masked    = DATA_W'(cfg_start);
        name      = "start_state";
      end
      REG_ALPHA: begin
        cfg_alpha = value[ALPHA_W-1:0];
        masked    = DATA_W'(cfg_alpha);
        name      = "alphabet_mask";
      end
      default: begin
        cfg_final = value[FINAL_W-1:0];
        masked    = DATA_W'(cfg_final);
        name      = "final_mask";
      end
    endcase
    read_register(idx, name, masked);
  endtask

  task automatic load_config(input logic [DATA_W-1:0] start_v, input logic [DATA_W-1:0] alpha_v,
                             input logic [DATA_W-1:0] final_v);
    wait_idle();
    set_register(REG_START, start_v);
    set_register(REG_ALPHA, alpha_v);
    set_register(REG_FINAL, final_v);
  endtask

  // Registers read zero after reset; with an empty alphabet every character is rejected.
  task automatic test_reset_values();
    read_register(REG_START, "start_state", '0);
    read_register(REG_ALPHA, "alphabet_mask", '0);
    read_register(REG_FINAL, "final_mask", '0);
    send_empty();
    send_char(DIGIT_ZERO, 1'b1);
  endtask

  // Hand-built automaton that walks each special case once.
  task automatic test_directed_strings();
    load_config(32'd3, 32'h1FF, 32'h8008);
    send_write(4'd3, 4'd0, 4'd15);
    send_write(4'd15, 4'd8, 4'd3);
    send_write(4'd15, 4'd1, 4'd4);
    send_write(4'd3, 4'd1, 4'd0);
    // Symbol past the table width must not land in the next row.
    send_write(4'd3, 4'd10, 4'd7);
    // Accepted strings ending in the highest state and back at the start.
    send_char(DIGIT_ZERO, 1'b1);
    send_char(DIGIT_ZERO, 1'b0);
    send_char(DIGIT_ZERO + 8'd8, 1'b1);
    // Missing transition, and the digit nine left out of the alphabet.
    send_char(DIGIT_ZERO + 8'd1, 1'b1);
    send_char(DIGIT_ZERO, 1'b0);
    send_char(DIGIT_ZERO + 8'd9, 1'b1);
    // The unused operation is ignored and an empty item closes the string.
    send_char(DIGIT_ZERO, 1'b0);
    send_noop();
    send_empty();
    // Empty string with no string in progress.
    send_empty();
    // Bytes below and above the digits; later characters are ignored once rejected.
    send_char(DIGIT_ZERO - 8'd1, 1'b1);
    send_char(8'hFF, 1'b0);
    send_char(DIGIT_ZERO, 1'b1);
    send_char(DIGIT_ZERO + 8'd10, 1'b1);
    send_char(8'h00, 1'b1);
    // Reaches the row that an aliased write would have corrupted.
    send_char(DIGIT_ZERO, 1'b0);
    send_char(DIGIT_ZERO + 8'd1, 1'b0);
    send_char(DIGIT_ZERO, 1'b1);
  endtask

  // Mostly well-formed strings over the live table, with noise mixed in.
  task automatic run_random_phase(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    logic [CODE_W-1:0] code;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_write(STATE_W'($urandom_range(0, 15)),
                   SYM_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(0, 9)),
                   STATE_W'(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 15)));
      end else if (pick < 11) begin
        send_noop();
      end else if (pick < 15) begin
        send_empty();
      end else if (pick < 21) begin
        send_char(CODE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(1, 7);
        for (int unsigned i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0)
            send_write(STATE_W'($urandom_range(0, 15)), SYM_W'($urandom_range(0, 9)),
                       STATE_W'($urandom_range(1, 15)));
          code = ($urandom_range(0, 9) == 0) ? CODE_W'($urandom_range(0, 255)) : pick_digit();
          send_char(code, i == len - 1);
        end
      end
    end
    if (dfa_in_string) send_empty();
  endtask

  // Full table load, then phases under several settings including the extremes.
  task automatic test_random_strings();
    load_config(32'd0, 32'h3FF, 32'hFFFF);
    for (int unsigned q = 0; q < N_STATES; q++)
      for (int unsigned s = 0; s < N_SYMBOLS; s++)
        send_write(STATE_W'(q), SYM_W'(s),
                   STATE_W'(($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 15)));
    run_random_phase(150);
    load_config(32'd15, 32'h3FF, 32'h0000);
    gaps_on = 1'b0;
    run_random_phase(120);
    gaps_on = 1'b1;
    load_config($urandom(), $urandom(), $urandom());
    run_random_phase(150);
    load_config(32'hFFFF_FFF0, 32'h0000, $urandom());
    run_random_phase(60);
    load_config($urandom(), 32'hFFFF_FFFF, $urandom());
    run_random_phase(150);
    load_config($urandom(), $urandom() | 32'h0FF, 32'hAAAA);
    run_random_phase(120);
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_req <= 1'b1;
    gaps_on = 1'b0;
    for (int unsigned i = 0; i < 120; i++) begin
      if ($urandom_range(0, 1) == 0) send_empty();
      else send_char(pick_digit(), 1'b1);
    end
    gaps_on = 1'b1;
  endtask

  // Result side: checks each transfer and decides the next pop.
  always @(posedge clk_i) begin : result_side
    res_t want;
    logic next_pop;
    static rx_mode_e rx_mode = RX_FREE;
    static int unsigned mode_left = 0;
    static int unsigned hold_left = 0;
    static int unsigned rx_cycle = 0;
    static bit hold_done = 1'b0;
    if (rst_ni && pop && !empty) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result: accepted %0b, end_state %0d", accepted_o, end_state_o);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (accepted_o !== want.accepted) begin
          $error("accepted: expected %0b, actual %0b", want.accepted, accepted_o);
          fail_count++;
        end
        if (end_state_o !== want.end_state) begin
          $error("end_state: expected %0d, actual %0d", want.end_state, end_state_o);
          fail_count++;
        end
      end
    end
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      next_pop = 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      next_pop  = 1'b0;
    end else if (tail_mode) begin
      next_pop = 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (rx_mode)
        RX_FREE:   next_pop = 1'b1;
        RX_RANDOM: next_pop = 1'($urandom_range(0, 1));
        RX_SPARSE: next_pop = ($urandom_range(0, 3) == 0);
        default:   next_pop = (rx_cycle % 5 != 0);
      endcase
    end
    pop <= next_pop;
  end

  // Ends the run when no transfer of any kind happens for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || (psel && penable)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_ni       <= 1'b0;
    push         <= 1'b0;
    op_i         <= '0;
    from_state_i <= '0;
    symbol_in_i  <= '0;
    dest_state_i <= '0;
    char_code_i  <= '0;
    last_char_i  <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    hold_req     <= 1'b0;
    tail_mode    <= 1'b0;
    gaps_on       = 1'b1;
    burst_left    = 0;
    for (int unsigned q = 0; q < N_STATES; q++)
      for (int unsigned s = 0; s < N_SYMBOLS; s++)
        trans_tbl[q][s] = '0;
    dfa_state     = '0;
    dfa_rejected  = 1'b0;
    dfa_in_string = 1'b0;
    cfg_start     = '0;
    cfg_alpha     = '0;
    cfg_final     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_directed_strings();
    test_random_strings();
    test_backpressure();

    // Drain, then keep popping so that a stray result would still be caught.
    wait_idle();
    tail_mode <= 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
